// ===== rtl/der_subject_name_extractor_top_assert.svh =====
// assertion macros for the der subject name extractor
`ifndef DER_SUBJECT_NAME_EXTRACTOR_TOP_ASSERT_SVH
`define DER_SUBJECT_NAME_EXTRACTOR_TOP_ASSERT_SVH

`ifndef SYNTH
// clocked property, disabled while reset is high
`define DSNE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked property, checked in reset too
`define DSNE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSNE_ASSERT(lbl, clk, rst, prop, msg)
`define DSNE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/dsne_pkg.sv =====
package dsne_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [4:0] step_type;
   typedef logic [1:0] act_type;
   typedef logic [1:0] outcome_type;

   // expected tags
   localparam byte_type TAG_SEQUENCE = 8'h30;
   localparam byte_type TAG_SET      = 8'h31;
   localparam byte_type TAG_INTEGER  = 8'h02;
   localparam byte_type TAG_OID      = 8'h06;
   localparam byte_type TAG_UTF8     = 8'h0C;
   localparam byte_type TAG_CTX0     = 8'hA0;

   // length forms
   localparam byte_type LEN_INDEF = 8'h80;
   localparam byte_type LEN_LONG1 = 8'h81;
   localparam byte_type LEN_LONG2 = 8'h82;
   localparam byte_type LEN_LONG3 = 8'h83;
   localparam byte_type LEN_LONG4 = 8'h84;

   localparam step_type STEP_COUNT = 5'd17;
   localparam step_type NAME_STEP  = 5'd16;

   localparam act_type ACT_ENTER = 2'd0;
   localparam act_type ACT_SKIP  = 2'd1;
   localparam act_type ACT_NAME  = 2'd2;

   localparam outcome_type OUT_NONE = 2'd0;
   localparam outcome_type OUT_OK   = 2'd1;
   localparam outcome_type OUT_FAIL = 2'd2;

   function automatic byte_type step_tag(input step_type step);
      byte_type tag;
      case (step)
         5'd0, 5'd1:           tag = TAG_SEQUENCE;
         5'd2:                 tag = TAG_CTX0;
         5'd3, 5'd4:           tag = TAG_INTEGER;
         5'd5, 5'd6:           tag = TAG_SEQUENCE;
         5'd7:                 tag = TAG_SET;
         5'd8:                 tag = TAG_SEQUENCE;
         5'd9:                 tag = TAG_OID;
         5'd10:                tag = TAG_UTF8;
         5'd11, 5'd12:         tag = TAG_SEQUENCE;
         5'd13:                tag = TAG_SET;
         5'd14:                tag = TAG_SEQUENCE;
         5'd15:                tag = TAG_OID;
         5'd16:                tag = TAG_UTF8;
         default:              tag = 8'h00;
      endcase
      return tag;
   endfunction

   function automatic act_type step_act(input step_type step);
      act_type act;
      case (step)
         5'd0, 5'd1, 5'd2:     act = ACT_ENTER;
         5'd3, 5'd4, 5'd5:     act = ACT_SKIP;
         5'd6, 5'd7, 5'd8:     act = ACT_ENTER;
         5'd9, 5'd10, 5'd11:   act = ACT_SKIP;
         5'd12, 5'd13, 5'd14:  act = ACT_ENTER;
         5'd15:                act = ACT_SKIP;
         5'd16:                act = ACT_NAME;
         default:              act = ACT_SKIP;
      endcase
      return act;
   endfunction

endpackage

// ===== rtl/dsne_if.sv =====
// request channel: one certificate byte per transaction
interface dsne_req_if import dsne_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// response channel: name byte and/or final status
interface dsne_rsp_if import dsne_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     name_valid;
   byte_type name_byte;
   logic     done_res;
   logic     status;

   modport source (output valid, output name_valid, output name_byte,
                   output done_res, output status, input ready);
   modport sink   (input valid, input name_valid, input name_byte,
                   input done_res, input status, output ready);
endinterface

// ===== rtl/der_subject_name_extractor_top.sv =====
// der subject name extractor
// req_ch carries one certificate byte per transaction (data_byte, last marks
// the final byte of the buffer). rsp_ch returns at most one transaction per
// byte: a subject name byte (name_valid), the final status (done_res, status
// 0 ok / 1 fail), or both on the same transaction.
// csr_wr_en/csr_wr_data write emit_name; with emit_name low only the
// structure is verified and no name bytes are returned.
// a response is registered and appears on rsp_ch in the cycle after its byte is taken.
// throughput: one byte per cycle; the parser state step, phase, length and
// content counters is updated by one pass of logic per byte.
// when rsp_ch stalls the response holds in the output register and req_ch
// ready drops until it is taken; bytes keep flowing when it drains.
// after done, bytes are swallowed until one with last set, which re-arms the
// parser for the next certificate.
// reset (synchronous, active high) re-arms the parser, sets emit_name and
// empties the output register; no clearing pass is needed.
`include "der_subject_name_extractor_top_assert.svh"

module der_subject_name_extractor_top
   import dsne_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   dsne_req_if.sink   req_ch,
   dsne_rsp_if.source rsp_ch,
   input  logic     csr_wr_en,
   input  logic     csr_wr_data
);

   // parser phases
   localparam logic [1:0] PH_TAG  = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_LENX = 2'd2;
   localparam logic [1:0] PH_BODY = 2'd3;

   // parser state
   step_type    step_ff,     step_in;
   logic [1:0]  phase_ff,    phase_in;
   logic [31:0] len_ff,      len_in;
   logic [2:0]  len_left_ff, len_left_in;
   logic [31:0] rem_ff,      rem_in;
   logic        finished_ff, finished_in;
   logic        emit_name_ff;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        name_valid_ff;
   byte_type    name_byte_ff;
   logic        done_ff;
   logic        status_ff;

   // per byte working values
   logic        accept;
   logic        ld_fire;
   logic [31:0] ld_len;
   outcome_type outcome;
   logic        name_out;
   logic        has_result;
   logic [31:0] rem_dec;
   logic [2:0]  left_dec;
   act_type     act;
   byte_type    b;

   // take a byte whenever the output register is free or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign b   = req_ch.data_byte;
   assign act = step_act(step_ff);

   always_comb begin
      step_in     = step_ff;
      phase_in    = phase_ff;
      len_in      = len_ff;
      len_left_in = len_left_ff;
      rem_in      = rem_ff;
      finished_in = finished_ff;
      ld_fire     = 1'b0;
      ld_len      = len_ff;
      outcome     = OUT_NONE;
      name_out    = 1'b0;
      rem_dec     = (rem_ff != 32'd0) ? rem_ff - 32'd1 : rem_ff;
      left_dec    = (len_left_ff != 3'd0) ? len_left_ff - 3'd1 : len_left_ff;

      if (finished_ff) begin
         // swallowing trailing bytes
      end else if (step_ff >= STEP_COUNT) begin
         outcome = OUT_FAIL;
      end else begin
         case (phase_ff)
            PH_TAG: begin
               if (b != step_tag(step_ff)) outcome = OUT_FAIL;
               else                        phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (b < LEN_INDEF) begin
                  // short form
                  ld_fire = 1'b1;
                  ld_len  = {24'd0, b};
               end else if (b >= LEN_LONG1 && b <= LEN_LONG4) begin
                  len_left_in = b[2:0];
                  len_in      = 32'd0;
                  phase_in    = PH_LENX;
               end else begin
                  outcome = OUT_FAIL;
               end
            end
            PH_LENX: begin
               // big-endian length bytes
               ld_len      = {len_ff[23:0], b};
               len_in      = ld_len;
               len_left_in = left_dec;
               ld_fire     = (left_dec == 3'd0);
            end
            PH_BODY: begin
               rem_in = rem_dec;
               if (act == ACT_NAME) begin
                  name_out = emit_name_ff;
                  if (rem_dec == 32'd0) outcome = OUT_OK;
               end else if (rem_dec == 32'd0) begin
                  step_in  = step_ff + 5'd1;
                  phase_in = PH_TAG;
               end
            end
            default: outcome = OUT_FAIL;
         endcase

         // length complete: enter, skip or start the name
         if (ld_fire) begin
            len_in = ld_len;
            if (act == ACT_ENTER) begin
               step_in  = step_ff + 5'd1;
               phase_in = PH_TAG;
            end else if (ld_len == 32'd0) begin
               if (act == ACT_NAME) begin
                  outcome = OUT_OK;
               end else begin
                  step_in  = step_ff + 5'd1;
                  phase_in = PH_TAG;
               end
            end else begin
               rem_in   = ld_len;
               phase_in = PH_BODY;
            end
         end

         // buffer ran out before the name was complete
         if (outcome == OUT_NONE && req_ch.last) outcome = OUT_FAIL;
         if (outcome != OUT_NONE) finished_in = 1'b1;
      end

      // a last byte re-arms, whether done now or already done
      if ((finished_ff || outcome != OUT_NONE) && req_ch.last) begin
         step_in     = 5'd0;
         phase_in    = PH_TAG;
         len_in      = 32'd0;
         len_left_in = 3'd0;
         rem_in      = 32'd0;
         finished_in = 1'b0;
      end
   end

   assign has_result = (outcome != OUT_NONE) || name_out;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)            rsp_valid_in = has_result;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 5'd0;
         phase_ff     <= PH_TAG;
         len_ff       <= 32'd0;
         len_left_ff  <= 3'd0;
         rem_ff       <= 32'd0;
         finished_ff  <= 1'b0;
         emit_name_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            step_ff     <= step_in;
            phase_ff    <= phase_in;
            len_ff      <= len_in;
            len_left_ff <= len_left_in;
            rem_ff      <= rem_in;
            finished_ff <= finished_in;
         end
         if (csr_wr_en) emit_name_ff <= csr_wr_data;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept && has_result) begin
         name_valid_ff <= name_out;
         name_byte_ff  <= name_out ? b : 8'h00;
         done_ff       <= (outcome != OUT_NONE);
         status_ff     <= (outcome == OUT_FAIL);
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.name_valid = name_valid_ff;
   assign rsp_ch.name_byte  = name_byte_ff;
   assign rsp_ch.done_res   = done_ff;
   assign rsp_ch.status     = status_ff;

   // the script never runs past the name step
   `DSNE_ASSERT(a_step_range, clock, reset, (step_ff <= NAME_STEP), "script step out of range")
   // pending length bytes only while reading the long form
   `DSNE_ASSERT(a_len_left_phase, clock, reset, (len_left_ff != 3'd0) |-> (phase_ff == PH_LENX), "length bytes left outside long form")
   // trailing bytes without last keep the parser parked
   `DSNE_ASSERT(a_finished_hold, clock, reset, (accept && finished_ff && !req_ch.last) |=> (finished_ff && !rsp_valid_ff), "parser left done state or answered a trailing byte")
   // a failure is only ever reported as a done result
   `DSNE_ASSERT(a_status_done, clock, reset, (rsp_valid_ff && status_ff) |-> done_ff, "failure status without done")
   // the output register is empty straight after reset
   `DSNE_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid_ff, "response valid after reset")

endmodule
